[rtl/oft_pkg.sv]
package oft_pkg;

  // Default number of table entries
  localparam int TableDepthDef = 16;

  // Field widths
  localparam int NameW    = 64;
  localparam int ClusterW = 28;
  localparam int ModeW    = 2;
  localparam int KindW    = 2;
  localparam int StatusW  = 2;

  // Request kinds
  localparam logic [KindW-1:0] KIND_QUERY  = 2'd0;
  localparam logic [KindW-1:0] KIND_ADD    = 2'd1;
  localparam logic [KindW-1:0] KIND_REMOVE = 2'd2;

  // Result status codes
  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StatusW-1:0] ST_ALREADY   = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd3;

  // One table entry, also used as the broadcast search key
  typedef struct packed {
    logic [NameW-1:0]    name_high;
    logic [NameW-1:0]    name_low;
    logic [ClusterW-1:0] cluster;
    logic [ModeW-1:0]    mode;
  } entry_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic             active;
    logic             found;
    logic             wrote;
    logic [ModeW-1:0] mode;
  } tok_t;

  // Clear every byte after the first zero byte of the 16-byte name
  function automatic logic [2*NameW-1:0] normalize_name(input logic [2*NameW-1:0] name);
    logic [2*NameW-1:0] res;
    logic               ended;
    res   = name;
    ended = 1'b0;
    for (int b = 0; b < 16; b++) begin
      if (ended) begin
        res[2*NameW-1-8*b -: 8] = 8'h00;
      end else if (name[2*NameW-1-8*b -: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

[rtl/oft_cell.sv]
module oft_cell import oft_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int IDX         = 0,
  localparam int CntW       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tok_t             tok_i,
  output tok_t             tok_o,
  input  entry_t           key_i,
  input  logic [KindW-1:0] kind_i,
  input  logic [CntW-1:0]  total_i,
  input  entry_t           nxt_entry_i,
  input  logic             nxt_shift_i,
  output entry_t           entry_o,
  output logic             shift_o
);

  entry_t entry_q;
  tok_t   tok_q, tok_d;
  logic   valid, match, hit, wr;

  // Compare the broadcast key against the held entry while the token sits here
  always_comb begin
    valid   = CntW'(IDX) < total_i;
    match   = valid && (entry_q.name_high == key_i.name_high)
                    && (entry_q.name_low  == key_i.name_low)
                    && (entry_q.cluster   == key_i.cluster);
    hit     = tok_i.active && !tok_i.found && match;
    wr      = tok_i.active && !tok_i.found && (kind_i == KIND_ADD) && (total_i == CntW'(IDX));
    shift_o = tok_i.active && tok_i.found && (kind_i == KIND_REMOVE) && valid;
    tok_d.active = tok_i.active;
    tok_d.found  = tok_i.found | hit;
    tok_d.wrote  = tok_i.wrote | wr;
    tok_d.mode   = hit ? entry_q.mode : tok_i.mode;
  end

  // Advance the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // Store a new entry, or pull the neighbour's entry down on a remove
  always_ff @(posedge clk_i) begin
    if (wr) begin
      entry_q <= key_i;
    end else if (nxt_shift_i) begin
      entry_q <= nxt_entry_i;
    end
  end

  assign tok_o   = tok_q;
  assign entry_o = entry_q;

endmodule

[rtl/open_file_table.sv]
// Open file table: one request in flight at a time, one result word per request.
// The search token passes from the launch register through the chain of entry cells,
// one cell per cycle, and then into the result register that drives valid_o; a new
// request is not accepted until the token has left the last cell.
// Reset (rst_ni low, asynchronous) empties the table; entry contents are not cleared.
// The result is shown for one cycle only; the receiver cannot stall it.
module open_file_table import oft_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDef,
  localparam int CntW       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [KindW-1:0]    kind_i,
  input  logic [NameW-1:0]    name_high_i,
  input  logic [NameW-1:0]    name_low_i,
  input  logic [ClusterW-1:0] cluster_i,
  input  logic [ModeW-1:0]    mode_i,
  output logic                valid_o,
  output logic [StatusW-1:0]  status_o,
  output logic [ModeW-1:0]    mode_out_o,
  output logic [CntW-1:0]     open_count_o
);

  logic               busy_q;
  logic               valid_q;
  tok_t               launch_q;
  entry_t             key_q;
  logic [KindW-1:0]   kind_q;
  logic [CntW-1:0]    total_q, total_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [ModeW-1:0]   mode_out_q, mode_out_d;
  logic [2*NameW-1:0] norm_name;
  logic               accept;

  tok_t   tok_in  [TABLE_DEPTH];
  tok_t   tok_out [TABLE_DEPTH];
  entry_t entry_w [TABLE_DEPTH];
  logic   shift_w [TABLE_DEPTH];
  tok_t   last_tok;

  assign accept    = start && !busy_q;
  assign norm_name = normalize_name({name_high_i, name_low_i});
  assign last_tok  = tok_out[TABLE_DEPTH-1];

  // Chain of entry cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t nxt_entry;
    logic   nxt_shift;
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign nxt_entry = '0;
      assign nxt_shift = 1'b0;
    end else begin : g_mid
      assign nxt_entry = entry_w[i+1];
      assign nxt_shift = shift_w[i+1];
    end
    if (i == 0) begin : g_first
      assign tok_in[i] = launch_q;
    end else begin : g_rest
      assign tok_in[i] = tok_out[i-1];
    end

    oft_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX         (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_i       (tok_in[i]),
      .tok_o       (tok_out[i]),
      .key_i       (key_q),
      .kind_i      (kind_q),
      .total_i     (total_q),
      .nxt_entry_i (nxt_entry),
      .nxt_shift_i (nxt_shift),
      .entry_o     (entry_w[i]),
      .shift_o     (shift_w[i])
    );
  end

  // Resolve the word once the token leaves the last cell
  always_comb begin
    status_d   = ST_NOT_FOUND;
    mode_out_d = '0;
    total_d    = total_q;
    case (kind_q)
      KIND_QUERY: begin
        if (last_tok.found) begin
          status_d   = ST_OK;
          mode_out_d = last_tok.mode;
        end
      end
      KIND_ADD: begin
        if (last_tok.found) begin
          status_d = ST_ALREADY;
        end else if (last_tok.wrote) begin
          status_d = ST_OK;
          total_d  = total_q + CntW'(1);
        end else begin
          status_d = ST_FULL;
        end
      end
      KIND_REMOVE: begin
        if (last_tok.found) begin
          status_d = ST_OK;
          total_d  = total_q - CntW'(1);
        end
      end
      default: begin
        status_d = ST_NOT_FOUND;
      end
    endcase
  end

  // Hold control state, launch the token and register the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      valid_q  <= 1'b0;
      launch_q <= '0;
      total_q  <= '0;
    end else begin
      launch_q.active <= accept;
      valid_q         <= last_tok.active;
      if (accept) begin
        busy_q <= 1'b1;
      end
      if (last_tok.active) begin
        busy_q  <= 1'b0;
        total_q <= total_d;
      end
    end
  end

  // Capture the request and the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q.name_high <= norm_name[2*NameW-1:NameW];
      key_q.name_low  <= norm_name[NameW-1:0];
      key_q.cluster   <= cluster_i;
      key_q.mode      <= mode_i;
      kind_q          <= kind_i;
    end
    if (last_tok.active) begin
      status_q   <= status_d;
      mode_out_q <= mode_out_d;
    end
  end

  assign busy         = busy_q;
  assign valid_o      = valid_q;
  assign status_o     = status_q;
  assign mode_out_o   = mode_out_q;
  assign open_count_o = total_q;

endmodule

[rtl/oft_checker.sv]
module oft_checker import oft_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDef,
  localparam int CntW       = $clog2(TABLE_DEPTH + 1)
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               valid_o,
  input logic [StatusW-1:0] status_o,
  input logic [ModeW-1:0]   mode_out_o,
  input logic [CntW-1:0]    open_count_o
);

  // An accepted request makes the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted request");

  // The result word appears with the block free again
  a_idle_at_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result shown while still busy");

  // The count never exceeds the table depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> open_count_o <= CntW'(TABLE_DEPTH))
    else $error("open count beyond table depth");

  // A failed request leaves the count unchanged
  a_fail_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != ST_OK |-> open_count_o == $past(open_count_o))
    else $error("count changed on a failed request");

  // A mode is only returned with an ok status
  a_mode_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && mode_out_o != '0 |-> status_o == ST_OK)
    else $error("mode returned without ok status");

endmodule

bind open_file_table oft_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_oft_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .valid_o      (valid_o),
  .status_o     (status_o),
  .mode_out_o   (mode_out_o),
  .open_count_o (open_count_o)
);
